FILE: sv/sdsc_pkg.sv
// Package for the disk seek distance and cost block.
// Holds the widths, register indexes, FSM state type and unit handshake structs.
// No dependencies.
package sdsc_pkg;

  // Address and cost widths
  localparam int ADDRESS_WIDTH = 32;
  localparam int COST_WIDTH    = 16;

  // Fixed field widths
  localparam int DIST_W  = 32;
  localparam int OUT_W   = 48;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int SSIZE_W = 16;
  localparam int PLAT_W  = 8;
  localparam int RATE_W  = 16;

  // Cost registers keep the low bits of both the field and the cost width
  localparam int COST_BITS = (COST_WIDTH < 16) ? COST_WIDTH : 16;
  localparam int PROD_W    = DIST_W + COST_BITS;
  localparam int MCNT_W    = $clog2(COST_BITS + 1);

  // Divider width: geometry needs 32 bits, the wrapped target needs ADDRESS_WIDTH
  localparam int DIV_W = (ADDRESS_WIDTH > 32) ? ADDRESS_WIDTH : 32;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] ADDR_MASK = DIV_W'({ADDRESS_WIDTH{1'b1}});

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SECT_BYTES = 3'd0;
  localparam logic [IDX_W-1:0] REG_PLATTERS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAPACITY   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SEEK_RATE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_REVERSE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_HEAT       = 3'd5;
  localparam logic [IDX_W-1:0] REG_ENERGY     = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEOM,
    ST_DIV_CAP,
    ST_DIV_PLAT,
    ST_CHECK,
    ST_MOD,
    ST_MOVE,
    ST_MUL,
    ST_DONE
  } sdsc_state_t;

  typedef struct packed {
    logic start;
  } sdsc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sdsc_stat_t;

endpackage

FILE: sv/sdsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sdsc_pkg.
module sdsc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  sdsc_pkg::sdsc_ctrl_t      ctrl,
  input  logic [sdsc_pkg::DIV_W-1:0] dividend,
  input  logic [sdsc_pkg::DIV_W-1:0] divisor,
  output logic [sdsc_pkg::DIV_W-1:0] quotient,
  output logic [sdsc_pkg::DIV_W-1:0] remainder,
  output sdsc_pkg::sdsc_stat_t      stat
);

  logic [sdsc_pkg::DIV_W-1:0] rem;
  logic [sdsc_pkg::DIV_W-1:0] quo;
  logic [sdsc_pkg::DIV_W-1:0] dvsr;
  logic [sdsc_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [sdsc_pkg::DIV_W:0]   rem_sh;
  logic [sdsc_pkg::DIV_W:0]   diff;
  logic                       ge;

  assign rem_sh = {rem, quo[sdsc_pkg::DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvsr});
  assign diff   = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= sdsc_pkg::CNT_W'(sdsc_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == sdsc_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[sdsc_pkg::DIV_W-1:0] : rem_sh[sdsc_pkg::DIV_W-1:0];
      quo <= {quo[sdsc_pkg::DIV_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: sv/sdsc_mul.sv
// Serial shift-add multiplier, two lanes sharing one multiplicand.
// One multiplier bit per cycle per lane. Depends on sdsc_pkg.
module sdsc_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  sdsc_pkg::sdsc_ctrl_t          ctrl,
  input  logic [sdsc_pkg::DIST_W-1:0]    mcand,
  input  logic [sdsc_pkg::COST_BITS-1:0] heat_cost,
  input  logic [sdsc_pkg::COST_BITS-1:0] energy_cost,
  output logic [sdsc_pkg::PROD_W-1:0]    heat_prod,
  output logic [sdsc_pkg::PROD_W-1:0]    energy_prod,
  output sdsc_pkg::sdsc_stat_t          stat
);

  logic [sdsc_pkg::DIST_W-1:0]    md;
  logic [sdsc_pkg::COST_BITS-1:0] mh;
  logic [sdsc_pkg::COST_BITS-1:0] me;
  logic [sdsc_pkg::PROD_W-1:0]    acc_h;
  logic [sdsc_pkg::PROD_W-1:0]    acc_e;
  logic [sdsc_pkg::MCNT_W-1:0]    cnt;
  logic                           busy;
  logic                           done;
  logic [sdsc_pkg::DIST_W:0]      sum_h;
  logic [sdsc_pkg::DIST_W:0]      sum_e;

  // add into the upper part, then shift the whole accumulator right
  assign sum_h = {1'b0, acc_h[sdsc_pkg::PROD_W-1:sdsc_pkg::COST_BITS]}
               + (mh[0] ? {1'b0, md} : '0);
  assign sum_e = {1'b0, acc_e[sdsc_pkg::PROD_W-1:sdsc_pkg::COST_BITS]}
               + (me[0] ? {1'b0, md} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= sdsc_pkg::MCNT_W'(sdsc_pkg::COST_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == sdsc_pkg::MCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      md    <= mcand;
      mh    <= heat_cost;
      me    <= energy_cost;
      acc_h <= '0;
      acc_e <= '0;
    end else if (busy) begin
      mh    <= mh >> 1;
      me    <= me >> 1;
      acc_h <= {sum_h, acc_h[sdsc_pkg::COST_BITS-1:1]};
      acc_e <= {sum_e, acc_e[sdsc_pkg::COST_BITS-1:1]};
    end
  end

  assign heat_prod   = acc_h;
  assign energy_prod = acc_e;
  assign stat.busy   = busy;
  assign stat.done   = done;

endmodule

FILE: sv/disk_seek_distance_cost_top.sv
// Disk seek distance and cost: head position tracker of an emulated disk.
// A request steps through the geometry check, two divisions when the cached sectors per
// platter is stale after a geometry register write, the target reduction modulo sectors
// per platter, the head move and the cost multiply; seeking off or zero sectors per platter
// skips to the result. One request at a time, the next taken the cycle after its result
// is loaded. Synchronous reset restores register defaults and head 0. Needs sdsc_pkg, _div, _mul.
module disk_seek_distance_cost_top (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_write,
  input  logic [sdsc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [sdsc_pkg::CFG_W-1:0]  cfg_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 target_sector,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 distance,
  output logic [47:0]                 heat_amount,
  output logic [47:0]                 energy_amount,
  output logic                        position_changed,
  output logic                        bad_geometry
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sdsc_pkg::SSIZE_W-1:0]   sect_bytes;
  logic [sdsc_pkg::PLAT_W-1:0]    num_platters;
  logic [31:0]                    capacity_bytes;
  logic [sdsc_pkg::RATE_W-1:0]    seek_rate;
  logic                           reverse_allowed;
  logic [sdsc_pkg::COST_BITS-1:0] heat_per_sector;
  logic [sdsc_pkg::COST_BITS-1:0] energy_per_sector;

  // Sectors per platter is cached; a geometry write invalidates it
  logic        geom_valid;
  logic [31:0] spp;

  always_ff @(posedge clk) begin
    if (rst) begin
      sect_bytes        <= sdsc_pkg::SSIZE_W'(512);
      num_platters      <= sdsc_pkg::PLAT_W'(1);
      capacity_bytes    <= 32'd1048576;
      seek_rate         <= '0;
      reverse_allowed   <= 1'b0;
      heat_per_sector   <= '0;
      energy_per_sector <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sdsc_pkg::REG_SECT_BYTES: sect_bytes        <= cfg_data[sdsc_pkg::SSIZE_W-1:0];
        sdsc_pkg::REG_PLATTERS:   num_platters      <= cfg_data[sdsc_pkg::PLAT_W-1:0];
        sdsc_pkg::REG_CAPACITY:   capacity_bytes    <= cfg_data[31:0];
        sdsc_pkg::REG_SEEK_RATE:  seek_rate         <= cfg_data[sdsc_pkg::RATE_W-1:0];
        sdsc_pkg::REG_REVERSE:    reverse_allowed   <= cfg_data[0];
        sdsc_pkg::REG_HEAT:       heat_per_sector   <= cfg_data[sdsc_pkg::COST_BITS-1:0];
        sdsc_pkg::REG_ENERGY:     energy_per_sector <= cfg_data[sdsc_pkg::COST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  sdsc_pkg::sdsc_state_t state, state_next;
  sdsc_pkg::sdsc_ctrl_t  div_ctrl, mul_ctrl;
  sdsc_pkg::sdsc_stat_t  div_stat, mul_stat;

  logic [sdsc_pkg::DIV_W-1:0] div_dividend, div_divisor;
  logic [sdsc_pkg::DIV_W-1:0] div_quo, div_rem;
  logic [sdsc_pkg::PROD_W-1:0] heat_prod, energy_prod;

  logic [sdsc_pkg::DIV_W-1:0] target_m1;     // target - 1, wrapped to address width
  logic [31:0]                head_position;
  logic [31:0]                res_dist;
  logic [47:0]                res_heat, res_energy;
  logic                       res_changed, res_bad;

  logic                       in_xfer, out_free;
  logic                       geom_zero;      // a divisor of the geometry is zero
  logic [sdsc_pkg::DIV_W-1:0] tgt, old_ext, spp_ext, wrap_dist;
  logic [31:0]                moved;
  logic                       moves;

  assign in_ready  = (state == sdsc_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign geom_zero = (sect_bytes == '0) || (num_platters == '0);

  // Head move, worked out once the reduced target is ready
  assign tgt       = div_rem;
  assign old_ext   = sdsc_pkg::DIV_W'(head_position);
  assign spp_ext   = sdsc_pkg::DIV_W'(spp);
  assign wrap_dist = (spp_ext - old_ext + tgt) & sdsc_pkg::ADDR_MASK;
  assign moves     = (tgt != old_ext);

  always_comb begin
    if (!moves) begin
      moved = '0;
    end else if (tgt > old_ext) begin
      moved = 32'(tgt - old_ext);
    end else if (reverse_allowed) begin
      moved = 32'(old_ext - tgt);
    end else begin
      moved = wrap_dist[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, divider operand select and unit start pulses
  always_comb begin
    state_next     = state;
    div_ctrl.start = 1'b0;
    mul_ctrl.start = 1'b0;
    div_dividend   = sdsc_pkg::DIV_W'(capacity_bytes);
    div_divisor    = sdsc_pkg::DIV_W'(sect_bytes);
    case (state)
      sdsc_pkg::ST_IDLE: begin
        if (in_xfer) state_next = sdsc_pkg::ST_GEOM;
      end
      sdsc_pkg::ST_GEOM: begin
        if (seek_rate == '0) begin
          state_next = sdsc_pkg::ST_DONE;
        end else if (geom_valid || geom_zero) begin
          state_next = sdsc_pkg::ST_CHECK;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = sdsc_pkg::ST_DIV_CAP;
        end
      end
      sdsc_pkg::ST_DIV_CAP: begin
        div_dividend = div_quo;
        div_divisor  = sdsc_pkg::DIV_W'(num_platters);
        if (div_stat.done) begin
          div_ctrl.start = 1'b1;
          state_next     = sdsc_pkg::ST_DIV_PLAT;
        end
      end
      sdsc_pkg::ST_DIV_PLAT: begin
        if (div_stat.done) state_next = sdsc_pkg::ST_CHECK;
      end
      sdsc_pkg::ST_CHECK: begin
        div_dividend = target_m1;
        div_divisor  = spp_ext;
        if (spp == '0) begin
          state_next = sdsc_pkg::ST_DONE;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = sdsc_pkg::ST_MOD;
        end
      end
      sdsc_pkg::ST_MOD: begin
        if (div_stat.done) state_next = sdsc_pkg::ST_MOVE;
      end
      sdsc_pkg::ST_MOVE: begin
        mul_ctrl.start = 1'b1;
        state_next     = sdsc_pkg::ST_MUL;
      end
      sdsc_pkg::ST_MUL: begin
        if (mul_stat.done) state_next = sdsc_pkg::ST_DONE;
      end
      sdsc_pkg::ST_DONE: begin
        if (out_free) state_next = sdsc_pkg::ST_IDLE;
      end
      default: state_next = sdsc_pkg::ST_IDLE;
    endcase
  end

  // Geometry cache and head position
  always_ff @(posedge clk) begin
    if (rst) begin
      geom_valid    <= 1'b0;
      spp           <= '0;
      head_position <= '0;
    end else begin
      if (cfg_write && (cfg_index == sdsc_pkg::REG_SECT_BYTES ||
                        cfg_index == sdsc_pkg::REG_PLATTERS ||
                        cfg_index == sdsc_pkg::REG_CAPACITY)) begin
        geom_valid <= 1'b0;
      end else if (state == sdsc_pkg::ST_GEOM && seek_rate != '0 &&
                   !geom_valid && geom_zero) begin
        geom_valid <= 1'b1;
        spp        <= '0;
      end else if (state == sdsc_pkg::ST_DIV_PLAT && div_stat.done) begin
        geom_valid <= 1'b1;
        spp        <= div_quo[31:0];
      end
      if (state == sdsc_pkg::ST_MOVE && moves) begin
        head_position <= tgt[31:0];
      end
    end
  end

  // Per-item result registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      target_m1   <= (sdsc_pkg::DIV_W'(target_sector) - 1'b1) & sdsc_pkg::ADDR_MASK;
      res_dist    <= '0;
      res_heat    <= '0;
      res_energy  <= '0;
      res_changed <= 1'b0;
      res_bad     <= 1'b0;
    end else begin
      case (state)
        sdsc_pkg::ST_CHECK: begin
          if (spp == '0) res_bad <= 1'b1;
        end
        sdsc_pkg::ST_MOVE: begin
          res_dist    <= moved;
          res_changed <= moves;
        end
        sdsc_pkg::ST_MUL: begin
          if (mul_stat.done) begin
            res_heat   <= 48'(heat_prod);
            res_energy <= 48'(energy_prod);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: holds a result while the next request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sdsc_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sdsc_pkg::ST_DONE && out_free) begin
      distance         <= res_dist;
      heat_amount      <= res_heat;
      energy_amount    <= res_energy;
      position_changed <= res_changed;
      bad_geometry     <= res_bad;
    end
  end

  // ---------------------------------------------------------------------------
  // Serial units
  // ---------------------------------------------------------------------------
  sdsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  sdsc_mul u_mul (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (mul_ctrl),
    .mcand       (moved),
    .heat_cost   (heat_per_sector),
    .energy_cost (energy_per_sector),
    .heat_prod   (heat_prod),
    .energy_prod (energy_prod),
    .stat        (mul_stat)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_bad_no_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_geometry |-> distance == '0 && !position_changed)
    else $error("bad geometry result carries a move");

  a_no_move_no_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && !position_changed |-> distance == '0 && heat_amount == '0 &&
                                       energy_amount == '0)
    else $error("cost reported without a head move");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == sdsc_pkg::ST_IDLE |-> !div_stat.busy && !mul_stat.busy)
    else $error("serial unit busy with no request in progress");

endmodule

FILE: tb/disk_seek_checker.sv
// Checker for the disk seek distance and cost block: tracks register writes,
// predicts one result per request transfer and compares result transfers in order.
// Depends on sdsc_pkg.
`timescale 1ns / 100ps

module disk_seek_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [sdsc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [sdsc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [31:0]                 target_sector,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [31:0]                 distance,
  input  logic [47:0]                 heat_amount,
  input  logic [47:0]                 energy_amount,
  input  logic                        position_changed,
  input  logic                        bad_geometry,
  output int                          errors,
  output int                          pending,
  output int                          checked
);

  typedef struct packed {
    logic [31:0] distance;
    logic [47:0] heat;
    logic [47:0] energy;
    logic        changed;
    logic        bad;
  } seek_result_t;

  // mirrored registers and head position
  logic [15:0] sect_size;
  logic [7:0]  plat_count;
  logic [31:0] capacity;
  logic [15:0] rate;
  logic        rev_ok;
  logic [15:0] heat_ps;
  logic [15:0] energy_ps;
  logic [31:0] head_pos;

  seek_result_t seek_results_q[$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  // travel and cost of one request; new_head is the head afterwards
  function automatic seek_result_t seek_cost(input logic [31:0] req,
                                             output logic [31:0] new_head);
    seek_result_t r;
    logic [31:0]  spp;
    logic [31:0]  tgt;
    logic [31:0]  moved;
    r        = '0;
    moved    = '0;
    spp      = '0;
    new_head = head_pos;
    if (rate == 16'd0) return r;
    if (sect_size != 16'd0 && plat_count != 8'd0)
      spp = (capacity / {16'd0, sect_size}) / {24'd0, plat_count};
    if (spp == 32'd0) begin
      r.bad = 1'b1;
      return r;
    end
    tgt = (req - 32'd1) % spp;
    if (tgt != head_pos) begin
      if (tgt > head_pos)
        moved = tgt - head_pos;
      else if (rev_ok)
        moved = head_pos - tgt;
      else
        moved = spp - head_pos + tgt;   // wraps at 32 bits on a stale head
      new_head  = tgt;
      r.changed = 1'b1;
    end
    r.distance = moved;
    r.heat     = 48'(heat_ps) * 48'(moved);
    r.energy   = 48'(energy_ps) * 48'(moved);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    seek_result_t want;
    logic [31:0]  nh;
    if (rst) begin
      sect_size  = 16'd512;
      plat_count = 8'd1;
      capacity   = 32'd1048576;
      rate       = '0;
      rev_ok     = 1'b0;
      heat_ps    = '0;
      energy_ps  = '0;
      head_pos   = '0;
      seek_results_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sdsc_pkg::REG_SECT_BYTES: sect_size  = cfg_data[15:0];
          sdsc_pkg::REG_PLATTERS:   plat_count = cfg_data[7:0];
          sdsc_pkg::REG_CAPACITY:   capacity   = cfg_data;
          sdsc_pkg::REG_SEEK_RATE:  rate       = cfg_data[15:0];
          sdsc_pkg::REG_REVERSE:    rev_ok     = cfg_data[0];
          sdsc_pkg::REG_HEAT:       heat_ps    = cfg_data[15:0];
          sdsc_pkg::REG_ENERGY:     energy_ps  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (seek_results_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = seek_results_q.pop_front();
          check_field("distance", 64'(want.distance), 64'(distance));
          check_field("heat_amount", 64'(want.heat), 64'(heat_amount));
          check_field("energy_amount", 64'(want.energy), 64'(energy_amount));
          check_field("position_changed", 64'(want.changed), 64'(position_changed));
          check_field("bad_geometry", 64'(want.bad), 64'(bad_geometry));
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        want     = seek_cost(target_sector, nh);
        head_pos = nh;
        seek_results_q.push_back(want);
      end
    end
    pending = seek_results_q.size();
  end

endmodule

FILE: tb/disk_seek_distance_cost_top_tb.sv
// Testbench top for disk_seek_distance_cost_top: clock, reset, register
// programming, request stimulus with random gaps and result back-pressure.
// Depends on sdsc_pkg, disk_seek_distance_cost_top and disk_seek_checker.
`timescale 1ns / 100ps

module disk_seek_distance_cost_top_tb;

  localparam int CYCLE_LIMIT   = 1_200_000;  // several times the slowest clean run
  localparam int DRAIN_CYCLES  = 150;        // covers the slowest request
  localparam int HOLD_CYCLES   = 400;        // long receiver hold-off
  localparam int RAND_PHASES   = 13;
  localparam int PHASE_ITEMS   = 148;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [sdsc_pkg::IDX_W-1:0]    cfg_index;
  logic [sdsc_pkg::CFG_W-1:0]    cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [31:0]                   target_sector;
  logic                          out_valid;
  logic                          out_ready;
  logic [31:0]                   distance;
  logic [47:0]                   heat_amount;
  logic [47:0]                   energy_amount;
  logic                          position_changed;
  logic                          bad_geometry;

  int errors;
  int pending;
  int checked;
  int cycle_count  = 0;
  int seeks_sent   = 0;
  int settings     = 0;

  // shared between the sender and the receiver
  bit quiet     = 1'b0;   // no idling on either side while set
  bit hold_req  = 1'b0;   // sender asks the receiver for one long hold-off
  bit hold_done = 1'b0;

  logic [31:0] geo_span;  // sectors per platter as the stimulus sees it
  logic [31:0] last_target;

  disk_seek_distance_cost_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_sector    (target_sector),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .distance         (distance),
    .heat_amount      (heat_amount),
    .energy_amount    (energy_amount),
    .position_changed (position_changed),
    .bad_geometry     (bad_geometry)
  );

  disk_seek_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_sector    (target_sector),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .distance         (distance),
    .heat_amount      (heat_amount),
    .energy_amount    (energy_amount),
    .position_changed (position_changed),
    .bad_geometry     (bad_geometry),
    .errors           (errors),
    .pending          (pending),
    .checked          (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side. Ready drops at random, 11 percent of the time, except in the
  // quiet stretch; once, on request, it stays low for HOLD_CYCLES so the
  // block fills and stalls its request input while the sender keeps offering.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  // Register write while idle. Called and returns at a falling edge; the
  // strobe is low again before the next write can raise it.
  task automatic write_reg(input logic [sdsc_pkg::IDX_W-1:0] idx,
                           input logic [sdsc_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // One request transfer, with an occasional gap before it. Valid stays up
  // from one request to the next when there is no gap.
  task automatic send_seek(input logic [31:0] tgt);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    target_sector <= tgt;
    last_target    = tgt;
    do @(posedge clk); while (!in_ready);
    seeks_sent++;
    @(negedge clk);
  endtask

  // Lower valid and wait until every result is back, so the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // Targets mostly land inside the platter so the head revisits positions;
  // the rest repeat the previous target or are full 32-bit values and the wrap corners.
  function automatic logic [31:0] pick_target(input logic [31:0] span,
                                              input logic [31:0] prev);
    logic [31:0] lim;
    lim = (span == 32'd0 || span > 32'd5000) ? 32'd5000 : span;
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return prev;
      3:       return $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
      default: return 32'd1 + $urandom_range(lim);
    endcase
  endfunction

  // Random register setting for one phase; a few phases pin the extremes.
  task automatic program_phase(input int ph);
    logic [15:0] ss;
    logic [7:0]  pc;
    logic [31:0] cap;
    logic [31:0] rate;
    logic [63:0] span64;
    case ($urandom_range(3))
      0:       ss = 16'd1;
      1:       ss = 16'd512;
      2:       ss = 16'hFFFF;
      default: ss = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(2))
      0:       pc = 8'd1;
      1:       pc = 8'd255;
      default: pc = 8'($urandom_range(1, 255));
    endcase
    span64 = 64'(ss) * 64'(pc);
    case ($urandom_range(4))
      0:       cap = 32'hFFFF_FFFF;
      1:       cap = $urandom();
      default: cap = 32'(span64 * 64'($urandom_range(1, 64)) + 64'($urandom_range(ss - 1)));
    endcase
    // top half is ignored
    rate = {16'($urandom_range(65535)), 16'($urandom_range(1, 65535))};
    if (ph == 0) begin
      ss  = 16'hFFFF;
      pc  = 8'd255;
      cap = 32'hFFFF_FFFF;
    end
    if (ph == 1) rate = 32'h0000_FFFF;
    if (ph == 4) cap = 32'(ss) - 32'd1;   // too small: no whole platter sector
    if (ph == 9) rate = 32'hFFFF_0000;    // seeking disabled, junk above the field
    write_reg(sdsc_pkg::REG_SECT_BYTES, {16'($urandom_range(65535)), ss});
    write_reg(sdsc_pkg::REG_PLATTERS, {24'($urandom()), pc});
    write_reg(sdsc_pkg::REG_CAPACITY, cap);
    write_reg(sdsc_pkg::REG_SEEK_RATE, rate);
    write_reg(sdsc_pkg::REG_REVERSE, $urandom());
    write_reg(sdsc_pkg::REG_HEAT, (ph == 2) ? 32'h0000_FFFF : $urandom());
    write_reg(sdsc_pkg::REG_ENERGY, (ph == 3) ? 32'h0000_0000 : $urandom());
    geo_span = (cap / 32'(ss)) / 32'(pc);
    settings++;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = sdsc_pkg::REG_SECT_BYTES;
    cfg_data      = '0;
    in_valid      = 1'b0;
    target_sector = '0;
    geo_span      = 32'd2048;
    last_target   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting: seeking disabled, every result is all zero.
    send_seek(32'd0);
    send_seek(32'hFFFF_FFFF);
    settle();

    // Default geometry gives 2048 sectors per platter.
    write_reg(sdsc_pkg::REG_SEEK_RATE, 32'd1);
    write_reg(sdsc_pkg::REG_HEAT, 32'h0000_FFFF);
    write_reg(sdsc_pkg::REG_ENERGY, 32'h0000_0100);
    settings++;
    send_seek(32'd1);            // already there: no move
    send_seek(32'd6);            // forwards
    send_seek(32'd4);            // backwards, wraps round the platter
    send_seek(32'd0);            // target zero wraps to all ones
    send_seek(32'hFFFF_FFFF);    // top target, backwards across the end
    send_seek(32'd2049);         // reduces to sector zero
    settle();

    write_reg(sdsc_pkg::REG_REVERSE, 32'd1);
    settings++;
    send_seek(32'd4);
    send_seek(32'd1);            // direct move backwards
    settle();

    // No whole sector per platter: flagged, head untouched.
    write_reg(sdsc_pkg::REG_SECT_BYTES, 32'd0);
    send_seek(32'd9);
    settle();
    write_reg(sdsc_pkg::REG_SECT_BYTES, 32'h0000_FFFF);
    write_reg(sdsc_pkg::REG_PLATTERS, 32'd255);
    write_reg(sdsc_pkg::REG_CAPACITY, 32'd100);
    send_seek(32'd9);
    settle();
    write_reg(sdsc_pkg::REG_SECT_BYTES, 32'd1);
    write_reg(sdsc_pkg::REG_PLATTERS, 32'd0);
    send_seek(32'd9);
    settle();
    settings += 3;

    // Largest platter, longest move and biggest costs.
    write_reg(sdsc_pkg::REG_PLATTERS, 32'd1);
    write_reg(sdsc_pkg::REG_CAPACITY, 32'hFFFF_FFFF);
    write_reg(sdsc_pkg::REG_ENERGY, 32'h0000_FFFF);
    send_seek(32'd0);
    send_seek(32'hFFFF_FFFF);
    settle();

    // Platter shrinks under a far head: the wrap distance goes round 32 bits.
    write_reg(sdsc_pkg::REG_CAPACITY, 32'd16);
    write_reg(sdsc_pkg::REG_REVERSE, 32'd0);
    send_seek(32'd3);
    settle();
    write_reg(sdsc_pkg::REG_HEAT, 32'd0);
    write_reg(sdsc_pkg::REG_ENERGY, 32'd0);
    settings += 3;
    send_seek(32'd10);
    settle();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      program_phase(ph);
      quiet = (ph == 6 || ph == 7);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_seek(pick_target(geo_span, last_target));
      settle();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d seek requests over %0d register settings, %0d results compared",
             seeks_sent, settings, checked);
    $display("Covered: seek off, zero geometry, wrap and direct reverse, stale head, stalls");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
